### hw/rtl/rqf_pkg.sv
package rqf_pkg;

    // Action codes carried on the input tuser
    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    // Fixed field widths of the stream payloads
    localparam int unsigned PROC_ID_W  = 8;
    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned OUT_ID_W   = 8;
    localparam int unsigned OCC_W      = 5;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned S_TUSER_W  = 2;
    localparam int unsigned M_TDATA_W  = 24;

    // Result field positions inside m_tdata
    localparam int unsigned OUT_ID_LSB    = 0;
    localparam int unsigned OUT_VALID_BIT = 8;
    localparam int unsigned DROPPED_BIT   = 9;
    localparam int unsigned EMPTY_BIT     = 10;
    localparam int unsigned FULL_BIT      = 11;
    localparam int unsigned OCC_LSB       = 12;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
        logic remove;
    } cell_ctrl_t;

endpackage

### hw/rtl/ready_queue_fifo_remove_by_id_core.sv
// Bounded ready queue of process ids held in a row of QUEUE_DEPTH cells, head in cell 0.
// Each input transaction (tuser = action, tdata = proc_id) pushes at the tail, pops the
// head, or removes the first entry equal to proc_id while the rest keep their order.
// An action acts on the cells when taken, and its result appears on the master side in the
// following cycle from an output register. A new transaction is taken in the same cycle
// that the previous result leaves, so with the master side always ready one transaction
// is taken per cycle; a stalled result holds the input side until it is taken. The clock
// limit is set by the match flag rippling through the cell row on remove. Push to a full
// queue sets dropped; pop of an empty queue and remove with no match leave the queue as
// it is. Action code 3 changes nothing and only reports status.
module ready_queue_fifo_remove_by_id_core #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned ID_WIDTH    = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [7:0] proc_id
    input  logic [rqf_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] action
    input  logic [rqf_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] out_id, [8] out_valid, [9] dropped, [10] is_empty, [11] is_full,
    // [16:12] occupancy, [23:17] zero
    output logic [rqf_pkg::M_TDATA_W-1:0]      m_tdata
);
    import rqf_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic                     accept;
    action_t                  action;
    cell_ctrl_t               ctrl;
    logic [ID_WIDTH-1:0]      key;
    logic [QUEUE_DEPTH-1:0]   cell_valid;
    logic [ID_WIDTH-1:0]      cell_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]     hit_chain;
    logic                     q_empty;
    logic                     q_full;
    logic                     hit_any;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [M_TDATA_W-1:0]     data_reg;
    logic [M_TDATA_W-1:0]     data_next;

    logic [ID_WIDTH-1:0]      res_id;
    logic                     res_valid;
    logic                     res_drop;
    logic [OUT_ID_W-1:0]      res_id8;
    logic [OCC_W-1:0]         occ5;

    assign s_tready = ~m_tvalid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign action   = action_t'(s_tuser);

    // Fit the incoming id to the stored width
    for (genvar b = 0; b < ID_WIDTH; b++)
    begin : g_key
        if (b < PROC_ID_W)
        begin : g_bit
            assign key[b] = s_tdata[b];
        end
        else
        begin : g_zero
            assign key[b] = 1'b0;
        end
    end

    // Decode the command for the cells
    always_comb
    begin
        ctrl = '0;
        if (accept)
        begin
            unique case (action)
                ACT_PUSH:   ctrl.push   = 1'b1;
                ACT_POP:    ctrl.pop    = 1'b1;
                ACT_REMOVE: ctrl.remove = 1'b1;
                default:    ctrl        = '0;
            endcase
        end
    end

    // Cell row, head at index 0
    assign hit_chain[0] = 1'b0;
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                lv;
        logic                rv;
        logic [ID_WIDTH-1:0] rid;
        if (i == 0)
        begin : g_head
            assign lv = 1'b1;
        end
        else
        begin : g_mid
            assign lv = cell_valid[i-1];
        end
        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign rv  = 1'b0;
            assign rid = '0;
        end
        else
        begin : g_next
            assign rv  = cell_valid[i+1];
            assign rid = cell_id[i+1];
        end
        rqf_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .key         (key),
            .left_valid  (lv),
            .right_valid (rv),
            .right_id    (rid),
            .hit_in      (hit_chain[i]),
            .hit_out     (hit_chain[i+1]),
            .valid       (cell_valid[i]),
            .id          (cell_id[i])
        );
    end

    assign q_empty = ~cell_valid[0];
    assign q_full  = cell_valid[QUEUE_DEPTH-1];
    assign hit_any = hit_chain[QUEUE_DEPTH];

    // Work out the result and the new count
    always_comb
    begin
        res_id     = '0;
        res_valid  = 1'b0;
        res_drop   = 1'b0;
        count_next = count_reg;
        unique case (action)
            ACT_PUSH:
            begin
                if (q_full)
                begin
                    res_drop = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_POP:
            begin
                if (!q_empty)
                begin
                    res_id     = cell_id[0];
                    res_valid  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (hit_any)
                begin
                    res_id     = key;
                    res_valid  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                res_id = '0;
            end
        endcase
    end

    // Fit the id and the count to the result fields
    for (genvar b = 0; b < OUT_ID_W; b++)
    begin : g_oid
        if (b < ID_WIDTH)
        begin : g_bit
            assign res_id8[b] = res_id[b];
        end
        else
        begin : g_zero
            assign res_id8[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < OCC_W; b++)
    begin : g_occ
        if (b < CW)
        begin : g_bit
            assign occ5[b] = count_next[b];
        end
        else
        begin : g_zero
            assign occ5[b] = 1'b0;
        end
    end

    // Pack the result transaction
    always_comb
    begin
        data_next = '0;
        data_next[OUT_ID_LSB +: OUT_ID_W] = res_id8;
        data_next[OUT_VALID_BIT]          = res_valid;
        data_next[DROPPED_BIT]            = res_drop;
        data_next[EMPTY_BIT]              = (count_next == '0);
        data_next[FULL_BIT]               = (count_next == CW'(QUEUE_DEPTH));
        data_next[OCC_LSB +: OCC_W]       = occ5;
    end

    assign m_tvalid_next = accept | (m_tvalid_reg & ~m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the result until the master side takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = data_reg;

endmodule

### hw/rtl/rqf_cell.sv
module rqf_cell #(
    parameter int unsigned ID_WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rqf_pkg::cell_ctrl_t ctrl,
    input  logic [ID_WIDTH-1:0] key,
    input  logic                left_valid,
    input  logic                right_valid,
    input  logic [ID_WIDTH-1:0] right_id,
    input  logic                hit_in,
    output logic                hit_out,
    output logic                valid,
    output logic [ID_WIDTH-1:0] id
);
    import rqf_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [ID_WIDTH-1:0] id_reg;
    logic [ID_WIDTH-1:0] id_next;
    logic                match;
    logic                shift;
    logic                load;

    // Compare against the key and pass the first-hit flag down the chain
    assign match   = valid_reg && (id_reg == key);
    assign hit_out = hit_in | match;

    // Take the neighbor's entry on pop, or at and after the first match on remove
    assign shift = ctrl.pop | (ctrl.remove & hit_out);
    // Load the pushed id into the first free cell
    assign load  = ctrl.push & left_valid & ~valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        priority if (shift)
        begin
            valid_next = right_valid;
            id_next    = right_id;
        end
        else if (load)
        begin
            valid_next = 1'b1;
            id_next    = key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the id payload; no reset needed
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;

endmodule

### hw/rtl/rqf_checker.sv
module rqf_checker #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rqf_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [rqf_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rqf_pkg::M_TDATA_W-1:0] m_tdata
);
    import rqf_pkg::*;

    // A stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Input side only backs off while a result is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // A refused push comes only with a full queue and no id
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[DROPPED_BIT] |->
            m_tdata[FULL_BIT] && !m_tdata[OUT_VALID_BIT]
            && (m_tdata[OUT_ID_LSB +: OUT_ID_W] == '0))
        else $error("drop reported with inconsistent status");

    // No id without a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[OUT_VALID_BIT] |-> (m_tdata[OUT_ID_LSB +: OUT_ID_W] == '0))
        else $error("id reported without a hit");

    // Empty never holds together with full or with a nonzero occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[EMPTY_BIT] |->
            !m_tdata[FULL_BIT] && (m_tdata[OCC_LSB +: OCC_W] == '0))
        else $error("empty flag disagrees with occupancy");

endmodule

bind ready_queue_fifo_remove_by_id_core rqf_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rqf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/tb_ready_queue_fifo_remove_by_id_core.sv
module tb_ready_queue_fifo_remove_by_id_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUEUE_DEPTH = 16;
    // Action code 3 is unused by the block: it leaves the queue alone
    localparam logic [1:0] ACT_NOP = 2'd3;
    // Cycles without any transaction before the run is given up
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned ITEMS_PER_PHASE = 425;

    // One result transaction, field by field
    typedef struct packed {
        logic [7:0] out_id;
        logic       out_valid;
        logic       dropped;
        logic       is_empty;
        logic       is_full;
        logic [4:0] occupancy;
    } queue_result_t;

    // Mirror of the ready queue plus the results still owed by the block
    class ready_queue_scoreboard;
        logic [7:0]    held_ids[$];
        queue_result_t owed_results[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endfunction

        // Apply one accepted request to the mirror and queue up its result
        function void note_request(logic [1:0] act, logic [7:0] id);
            queue_result_t res;
            bit            found;
            res = '0;
            found = 1'b0;
            case (act)
                rqf_pkg::ACT_PUSH:
                begin
                    if (held_ids.size() >= QUEUE_DEPTH)
                        res.dropped = 1'b1;
                    else
                        held_ids.push_back(id);
                end
                rqf_pkg::ACT_POP:
                begin
                    if (held_ids.size() > 0)
                    begin
                        res.out_id    = held_ids.pop_front();
                        res.out_valid = 1'b1;
                    end
                end
                rqf_pkg::ACT_REMOVE:
                begin
                    // Delete only the first match, the rest keep their order
                    for (int i = 0; i < held_ids.size(); i++)
                    begin
                        if (!found && held_ids[i] == id)
                        begin
                            found         = 1'b1;
                            res.out_id    = id;
                            res.out_valid = 1'b1;
                            held_ids.delete(i);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            res.is_empty  = (held_ids.size() == 0);
            res.is_full   = (held_ids.size() == QUEUE_DEPTH);
            res.occupancy = 5'(held_ids.size());
            owed_results.push_back(res);
        endfunction

        // Compare one result transaction with the oldest owed result
        function void check_result(logic [rqf_pkg::M_TDATA_W-1:0] data);
            queue_result_t want;
            if (owed_results.size() == 0)
            begin
                report($sformatf("result 0x%h with no request outstanding", data));
            end
            else
            begin
                want = owed_results.pop_front();
                if (data[rqf_pkg::OUT_ID_LSB +: rqf_pkg::OUT_ID_W] !== want.out_id)
                    report($sformatf("out_id 0x%h, want 0x%h",
                           data[rqf_pkg::OUT_ID_LSB +: rqf_pkg::OUT_ID_W], want.out_id));
                if (data[rqf_pkg::OUT_VALID_BIT] !== want.out_valid)
                    report($sformatf("out_valid %b, want %b",
                           data[rqf_pkg::OUT_VALID_BIT], want.out_valid));
                if (data[rqf_pkg::DROPPED_BIT] !== want.dropped)
                    report($sformatf("dropped %b, want %b",
                           data[rqf_pkg::DROPPED_BIT], want.dropped));
                if (data[rqf_pkg::EMPTY_BIT] !== want.is_empty)
                    report($sformatf("is_empty %b, want %b",
                           data[rqf_pkg::EMPTY_BIT], want.is_empty));
                if (data[rqf_pkg::FULL_BIT] !== want.is_full)
                    report($sformatf("is_full %b, want %b",
                           data[rqf_pkg::FULL_BIT], want.is_full));
                if (data[rqf_pkg::OCC_LSB +: rqf_pkg::OCC_W] !== want.occupancy)
                    report($sformatf("occupancy %0d, want %0d",
                           data[rqf_pkg::OCC_LSB +: rqf_pkg::OCC_W], want.occupancy));
                if (data[rqf_pkg::M_TDATA_W-1:rqf_pkg::OCC_LSB+rqf_pkg::OCC_W] !== '0)
                    report($sformatf("padding bits not zero in 0x%h", data));
            end
        endfunction
    endclass

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [rqf_pkg::S_TDATA_W-1:0]     s_tdata  = '0;
    logic [rqf_pkg::S_TUSER_W-1:0]     s_tuser  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [rqf_pkg::M_TDATA_W-1:0]     m_tdata;

    ready_queue_scoreboard queue_sb;
    int unsigned           send_idle_pct = 38;
    int unsigned           recv_idle_pct = 53;
    int unsigned           quiet_cycles  = 0;
    bit                    filling       = 1'b1;

    ready_queue_fifo_remove_by_id_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (8)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // Stall the result side at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Note accepted requests, check results, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                queue_sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                queue_sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_ready_queue_fifo_remove_by_id_core NOT OK");
                $finish;
            end
        end
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic [1:0] act, input logic [7:0] id);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= id;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Edge cases: empty queue, fill to full, overflow, head/tail/middle removal
    task automatic run_directed();
        logic [7:0] fill_ids [16] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
                                      8'h55, 8'h10, 8'h20, 8'h55, 8'h0F, 8'hF0, 8'h3C, 8'hC3};
        send_request(rqf_pkg::ACT_POP, 8'hFF);
        send_request(rqf_pkg::ACT_REMOVE, 8'h00);
        send_request(ACT_NOP, 8'hAA);
        foreach (fill_ids[i])
            send_request(rqf_pkg::ACT_PUSH, fill_ids[i]);
        send_request(rqf_pkg::ACT_PUSH, 8'h33);
        send_request(ACT_NOP, 8'h00);
        send_request(rqf_pkg::ACT_REMOVE, 8'h00);
        send_request(rqf_pkg::ACT_REMOVE, 8'hC3);
        send_request(rqf_pkg::ACT_REMOVE, 8'h55);
        send_request(rqf_pkg::ACT_REMOVE, 8'h99);
        send_request(rqf_pkg::ACT_POP, 8'h00);
    endtask

    // Random traffic that swings between filling and draining the queue
    task automatic run_random(input int unsigned count);
        int unsigned r;
        logic [1:0]  act;
        logic [7:0]  id;
        for (int unsigned n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 29) == 0)
                filling = !filling;
            r = $urandom_range(0, 99);
            if (r < 4)
                act = ACT_NOP;
            else if (filling)
                act = (r < 64) ? rqf_pkg::ACT_PUSH :
                      (r < 82) ? rqf_pkg::ACT_POP : rqf_pkg::ACT_REMOVE;
            else
                act = (r < 28) ? rqf_pkg::ACT_PUSH :
                      (r < 62) ? rqf_pkg::ACT_POP : rqf_pkg::ACT_REMOVE;
            // Mostly aim removals at ids that are held, else use a small or full id range
            if (act == rqf_pkg::ACT_REMOVE && queue_sb.held_ids.size() > 0
                && $urandom_range(0, 99) < 75)
                id = queue_sb.held_ids[$urandom_range(0, queue_sb.held_ids.size() - 1)];
            else if ($urandom_range(0, 1) == 1)
                id = 8'($urandom_range(0, 15));
            else
                id = 8'($urandom_range(0, 255));
            send_request(act, id);
        end
    endtask

    initial
    begin
        queue_sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 53;
        recv_idle_pct = 38;
        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(ITEMS_PER_PHASE);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then keep watching the result side for strays
        while (queue_sb.owed_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (queue_sb.errors == 0)
            $display("tb_ready_queue_fifo_remove_by_id_core OK");
        else
            $display("tb_ready_queue_fifo_remove_by_id_core NOT OK");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/rqf_pkg.sv
hw/rtl/rqf_cell.sv
hw/rtl/ready_queue_fifo_remove_by_id_core.sv
hw/rtl/rqf_checker.sv
test/tb_ready_queue_fifo_remove_by_id_core.sv
